// ----- src/alarm_clock_hour_minute_core_defines.svh -----
// Assertion macros for the alarm clock core.
`ifndef ALARM_CLOCK_HOUR_MINUTE_CORE_DEFINES_SVH
`define ALARM_CLOCK_HOUR_MINUTE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ACHM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ACHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACHM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ACHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/achm_pkg.sv -----
package achm_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_HOUR   = 2'd1,
        OP_MINUTE = 2'd2,
        OP_POLL   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_CLOCK  = 2'd0,
        MODE_CONFIG = 2'd1,
        MODE_ALARM  = 2'd2
    } t_mode;

    localparam logic [3:0]  SW_CONFIG   = 4'd1;
    localparam logic [3:0]  SW_ALARM    = 4'd2;
    localparam logic [5:0]  MINUTE_LAST = 6'd59;
    localparam logic [4:0]  HOUR_LAST   = 5'd23;
    localparam logic [6:0]  STOP_OFFSET = 7'd59;
    localparam logic [11:0] HOUR_SCALE  = 12'd100;

    typedef struct packed {
        logic [5:0] minute_now;
        logic [4:0] hour_now;
        logic [5:0] minute_alarm;
        logic [4:0] hour_alarm;
        t_mode      run_mode;
        logic       armed;
        logic       ringing;
        logic       buzzer;
        logic       heartbeat;
    } t_state;

endpackage

// ----- src/achm_if.sv -----
interface achm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [3:0] mode_switches;

    modport source (output valid, output opcode, output mode_switches, input ready);
    modport sink   (input valid, input opcode, input mode_switches, output ready);
endinterface

interface achm_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] display_value;
    logic        config_led;
    logic        alarm_mode_led;
    logic        buzzer;
    logic        heartbeat;
    logic        ringing;

    modport source (output valid, output display_value, output config_led,
                    output alarm_mode_led, output buzzer, output heartbeat,
                    output ringing, input ready);
    modport sink   (input valid, input display_value, input config_led,
                    input alarm_mode_led, input buzzer, input heartbeat,
                    input ringing, output ready);
endinterface

// ----- src/achm_update.sv -----
module achm_update (
    input  achm_pkg::t_state i_state,
    input  logic [1:0]       i_opcode,
    input  logic [3:0]       i_mode_switches,
    output achm_pkg::t_state o_state
);
    import achm_pkg::*;

    t_op        op;
    logic [5:0] min_inc;
    logic [4:0] hour_inc;
    logic [5:0] amin_inc;
    logic [4:0] ahour_inc;
    logic       hour_eq;

    assign op        = t_op'(i_opcode);
    assign min_inc   = (i_state.minute_now >= MINUTE_LAST) ? 6'd0 : i_state.minute_now + 6'd1;
    assign hour_inc  = (i_state.hour_now >= HOUR_LAST) ? 5'd0 : i_state.hour_now + 5'd1;
    assign amin_inc  = (i_state.minute_alarm >= MINUTE_LAST) ? 6'd0
                                                              : i_state.minute_alarm + 6'd1;
    assign ahour_inc = (i_state.hour_alarm >= HOUR_LAST) ? 5'd0 : i_state.hour_alarm + 5'd1;
    assign hour_eq   = (i_state.hour_now == i_state.hour_alarm);

    always_comb begin
        o_state = i_state;
        case (op)
            OP_TICK: begin
                o_state.minute_now = min_inc;
                if (i_state.minute_now >= MINUTE_LAST) begin
                    o_state.hour_now = hour_inc;
                end
                if (i_state.ringing) begin
                    o_state.buzzer = ~i_state.buzzer;
                end
                o_state.heartbeat = ~i_state.heartbeat;
            end
            OP_HOUR, OP_MINUTE: begin
                case (i_state.run_mode)
                    MODE_CONFIG: begin
                        if (op == OP_HOUR) begin
                            o_state.hour_now = hour_inc;
                        end else begin
                            o_state.minute_now = min_inc;
                        end
                    end
                    MODE_ALARM: begin
                        o_state.armed = 1'b1;
                        if (op == OP_HOUR) begin
                            o_state.hour_alarm = ahour_inc;
                        end else begin
                            o_state.minute_alarm = amin_inc;
                        end
                    end
                    default: begin
                        if (i_state.ringing) begin
                            o_state.ringing = 1'b0;
                            o_state.buzzer  = 1'b0;
                        end
                    end
                endcase
            end
            OP_POLL: begin
                if (i_mode_switches == SW_CONFIG) begin
                    o_state.run_mode = MODE_CONFIG;
                end else if (i_mode_switches == SW_ALARM) begin
                    o_state.run_mode = MODE_ALARM;
                end else begin
                    o_state.run_mode = MODE_CLOCK;
                end
                if (hour_eq && (i_state.minute_now == i_state.minute_alarm) && i_state.armed) begin
                    o_state.ringing = 1'b1;
                end else if (hour_eq && ({1'b0, i_state.minute_now}
                             == ({1'b0, i_state.minute_alarm} + STOP_OFFSET))) begin
                    o_state.ringing = 1'b0;
                    o_state.buzzer  = 1'b0;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ----- src/alarm_clock_hour_minute_core.sv -----
// Channel | Dir | Fields                                               | Accepted when
// i_in    | in  | opcode, mode_switches                                | valid & ready
// o_out   | out | display_value, config_led, alarm_mode_led, buzzer,   | valid & ready
//         |     | heartbeat, ringing                                   |
// One word in, one word out; a word is accepted every cycle unless o_out stalls.
// State update and display math sit between the input handshake and the result register.
// i_in.ready is high whenever the result register is empty or being drained.
// Synchronous active-low reset clears time, alarm, mode and flags to zero.
module alarm_clock_hour_minute_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    achm_in_if.sink          i_in,
    achm_out_if.source       o_out
);
    import achm_pkg::*;

    `include "alarm_clock_hour_minute_core_defines.svh"

    t_state      r_state;
    t_state      n_state;
    logic        r_valid;
    logic        accept;
    logic [11:0] disp;
    logic [4:0]  shown_hour;
    logic [5:0]  shown_min;

    logic [11:0] r_display;
    logic        r_config_led;
    logic        r_alarm_led;
    logic        r_buzzer;
    logic        r_heartbeat;
    logic        r_ringing;

    achm_update u_update (
        .i_state         (r_state),
        .i_opcode        (i_in.opcode),
        .i_mode_switches (i_in.mode_switches),
        .o_state         (n_state)
    );

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign shown_hour = (n_state.run_mode == MODE_ALARM) ? n_state.hour_alarm
                                                         : n_state.hour_now;
    assign shown_min  = (n_state.run_mode == MODE_ALARM) ? n_state.minute_alarm
                                                         : n_state.minute_now;
    assign disp       = ({7'd0, shown_hour} * HOUR_SCALE) + {6'd0, shown_min};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_display    <= disp;
            r_config_led <= (n_state.run_mode == MODE_CONFIG);
            r_alarm_led  <= (n_state.run_mode == MODE_ALARM);
            r_buzzer     <= n_state.buzzer;
            r_heartbeat  <= n_state.heartbeat;
            r_ringing    <= n_state.ringing;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.display_value  = r_display;
    assign o_out.config_led     = r_config_led;
    assign o_out.alarm_mode_led = r_alarm_led;
    assign o_out.buzzer         = r_buzzer;
    assign o_out.heartbeat      = r_heartbeat;
    assign o_out.ringing        = r_ringing;

    `ACHM_ASSERT(a_time_range, i_clk, i_rst_n, (r_state.minute_now <= MINUTE_LAST) && (r_state.hour_now <= HOUR_LAST), "time out of range")
    `ACHM_ASSERT(a_ring_armed, i_clk, i_rst_n, !r_state.ringing || r_state.armed, "ringing while unarmed")
    `ACHM_ASSERT(a_buzz_rise, i_clk, i_rst_n, !$rose(r_state.buzzer) || r_state.ringing, "buzzer rose while silent")
    `ACHM_ASSERT_NEXT(a_accept_out, i_clk, i_rst_n, accept, o_out.valid, "accepted word gave no result")
    `ACHM_ASSERT(a_led_excl, i_clk, i_rst_n, !(o_out.valid && o_out.config_led && o_out.alarm_mode_led), "both mode leds lit")

endmodule
